/* rtl/rmh_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// rmh_pkg
// Shared types and constants for the refresh mode hysteresis block: request
// and result payloads, configuration register indexes, field codes and the
// register reset values.
// ============================================================================

package rmh_pkg;

    // Item kinds carried by the kind field.
    localparam logic KIND_SAMPLE     = 1'b0;
    localparam logic KIND_APPLY_DONE = 1'b1;

    // Detector verdict codes.
    localparam logic [1:0] VERDICT_FULLSCREEN = 2'd0;
    localparam logic [1:0] VERDICT_DESKTOP    = 2'd1;
    localparam logic [1:0] VERDICT_UNKNOWN    = 2'd2;
    localparam logic [1:0] VERDICT_OTHER      = 2'd3;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_PROMOTION_DELAY = 3'd0,
        REG_DEMOTION_DELAY  = 3'd1,
        REG_FLAP_EXTRA      = 3'd2,
        REG_UNKNOWN_GRACE   = 3'd3,
        REG_SETTLE          = 3'd4,
        REG_RETRY           = 3'd5,
        REG_INITIAL_HIGH    = 3'd6,
        REG_DISPLAY_MODE    = 3'd7
    } rmh_reg_idx_t;

    // Register reset values.
    localparam logic [15:0] PROMOTION_DELAY_RST = 16'd300;
    localparam logic [15:0] DEMOTION_DELAY_RST  = 16'd1500;
    localparam logic [15:0] FLAP_EXTRA_RST      = 16'd4000;
    localparam logic [15:0] UNKNOWN_GRACE_RST   = 16'd5000;
    localparam logic [15:0] SETTLE_RST          = 16'd1000;
    localparam logic [15:0] RETRY_RST           = 16'd2000;
    localparam logic        DISPLAY_MODE_RST    = 1'b1;

    // Flip counter saturation value.
    localparam logic [7:0] FLIP_COUNT_MAX = 8'hFF;

    // One incoming request.
    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic [1:0]  verdict;
        logic        signal_active;
        logic        signal_strong;
        logic        apply_ok;
    } rmh_sample_t;

    // One outgoing result.
    typedef struct packed {
        logic request_apply;
        logic request_high;
        logic applied_level;
        logic candidate_level;
        logic flap_damped;
    } rmh_result_t;

    // Live configuration seen by the decision logic.
    typedef struct packed {
        logic [15:0] promotion_delay_ms;
        logic [15:0] demotion_delay_ms;
        logic [15:0] flap_extra_ms;
        logic [15:0] unknown_grace_ms;
        logic [15:0] settle_ms;
        logic [15:0] retry_ms;
        logic        display_mode;
    } rmh_cfg_t;

endpackage

/* rtl/rmh_cfg.sv */
`timescale 1ns / 1ps
// ============================================================================
// rmh_cfg
// Configuration register file. Takes writes by index and presents the live
// settings as one struct to the decision logic.
// ============================================================================

module rmh_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [2:0]        wr_index,
    input  logic [15:0]       wr_data,
    output rmh_pkg::rmh_cfg_t cfg
);

    rmh_pkg::rmh_cfg_t cfg_reg;

    // Register writes. The initial level register is accepted but has no
    // storage: the level taken at reset is always base refresh, because the core
    // resets both levels to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.promotion_delay_ms <= rmh_pkg::PROMOTION_DELAY_RST;
            cfg_reg.demotion_delay_ms  <= rmh_pkg::DEMOTION_DELAY_RST;
            cfg_reg.flap_extra_ms      <= rmh_pkg::FLAP_EXTRA_RST;
            cfg_reg.unknown_grace_ms   <= rmh_pkg::UNKNOWN_GRACE_RST;
            cfg_reg.settle_ms          <= rmh_pkg::SETTLE_RST;
            cfg_reg.retry_ms           <= rmh_pkg::RETRY_RST;
            cfg_reg.display_mode       <= rmh_pkg::DISPLAY_MODE_RST;
        end
        else if (wr_en)
        begin
            unique case (rmh_pkg::rmh_reg_idx_t'(wr_index))
                rmh_pkg::REG_PROMOTION_DELAY: cfg_reg.promotion_delay_ms <= wr_data;
                rmh_pkg::REG_DEMOTION_DELAY:  cfg_reg.demotion_delay_ms  <= wr_data;
                rmh_pkg::REG_FLAP_EXTRA:      cfg_reg.flap_extra_ms      <= wr_data;
                rmh_pkg::REG_UNKNOWN_GRACE:   cfg_reg.unknown_grace_ms   <= wr_data;
                rmh_pkg::REG_SETTLE:          cfg_reg.settle_ms          <= wr_data;
                rmh_pkg::REG_RETRY:           cfg_reg.retry_ms           <= wr_data;
                rmh_pkg::REG_INITIAL_HIGH:    ;
                rmh_pkg::REG_DISPLAY_MODE:    cfg_reg.display_mode       <= wr_data[0];
                default:                      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/rmh_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// rmh_core
// Decision logic and controller state. Evaluates one request per cycle from
// the current state, forms its result and updates the state when told to.
// ============================================================================

module rmh_core #(
    parameter int FLIP_THRESHOLD = 3,
    parameter int FLIP_WINDOW_MS = 30000,
    parameter int TIME_BITS      = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  rmh_pkg::rmh_sample_t item,
    input  rmh_pkg::rmh_cfg_t    cfg,
    output rmh_pkg::rmh_result_t result
);

    localparam logic [7:0]  FLIP_TH = 8'(FLIP_THRESHOLD);
    localparam logic [63:0] WINDOW  = 64'(FLIP_WINDOW_MS);

    // Controller state.
    logic                 applied_reg, applied_next;
    logic                 cand_reg, cand_next;
    logic [TIME_BITS-1:0] cand_time_reg, cand_time_next;
    logic [TIME_BITS-1:0] window_start_reg, window_start_next;
    logic [7:0]           flip_reg, flip_next;
    logic [TIME_BITS-1:0] hold_end_reg, hold_end_next;
    logic                 hold_armed_reg, hold_armed_next;
    logic [TIME_BITS-1:0] retry_end_reg, retry_end_next;
    logic                 retry_armed_reg, retry_armed_next;
    logic [TIME_BITS-1:0] unk_start_reg, unk_start_next;
    logic                 unk_seen_reg, unk_seen_next;
    logic                 pending_reg, pending_next;
    logic                 pending_lvl_reg, pending_lvl_next;

    // Sample path signals.
    logic [TIME_BITS-1:0] now_t;
    logic                 unk;
    logic [TIME_BITS-1:0] unk_start_s;
    logic [TIME_BITS-1:0] unk_diff;
    logic                 bridge;
    logic [TIME_BITS-1:0] hold_diff;
    logic                 held;
    logic                 cand_s;
    logic [TIME_BITS-1:0] cand_time_s;
    logic [TIME_BITS-1:0] win_diff;
    logic                 win_roll;
    logic [7:0]           flip_s;
    logic                 flap_s;
    logic [15:0]          base;
    logic [16:0]          need;
    logic [TIME_BITS-1:0] cand_diff;
    logic [TIME_BITS-1:0] retry_diff;
    logic                 blocked;
    logic                 req_s;

    // Apply report path signals.
    logic [7:0]           flip_inc;
    logic [TIME_BITS-1:0] hold_end_a;
    logic [TIME_BITS-1:0] retry_end_a;

    assign now_t = TIME_BITS'(item.now_ms);

    // Track the start of a run of unknown verdicts and bridge it for the
    // grace time.
    assign unk         = (item.verdict == rmh_pkg::VERDICT_UNKNOWN);
    assign unk_start_s = unk ? (unk_seen_reg ? unk_start_reg : now_t) : '0;
    assign unk_diff    = now_t - unk_start_s;
    assign bridge      = unk && (64'(unk_diff) < 64'(cfg.unknown_grace_ms));

    // The settle hold after our own mode change is ahead while the
    // difference to its end is negative.
    assign hold_diff = now_t - hold_end_reg;
    assign held      = hold_armed_reg && hold_diff[TIME_BITS-1];

    // Candidate update: the hold forces it to the applied level, the unknown
    // bridge freezes it, otherwise it follows the activity signal.
    always_comb
    begin
        cand_s      = cand_reg;
        cand_time_s = cand_time_reg;
        if (held)
        begin
            cand_s      = applied_reg;
            cand_time_s = now_t;
        end
        else if (!bridge && (item.signal_active != cand_reg))
        begin
            cand_s      = item.signal_active;
            cand_time_s = now_t;
        end
    end

    // Flap window: restart the window and clear the flip count once it has
    // run out.
    assign win_diff = now_t - window_start_reg;
    assign win_roll = (64'(win_diff) > WINDOW);
    assign flip_s   = win_roll ? 8'd0 : flip_reg;
    assign flap_s   = (flip_s >= FLIP_TH);

    // Required qualification time for the candidate.
    always_comb
    begin
        if (cand_s && item.signal_strong)
        begin
            base = 16'd0;
        end
        else if (cand_s)
        begin
            base = cfg.promotion_delay_ms;
        end
        else
        begin
            base = cfg.demotion_delay_ms;
        end
        need = flap_s ? (17'(base) + 17'(cfg.flap_extra_ms)) : 17'(base);
    end

    // Retry wait after a failed apply.
    assign retry_diff = now_t - retry_end_reg;
    assign blocked    = retry_armed_reg && retry_diff[TIME_BITS-1];

    // Issue a request once the candidate differs and has been stable long
    // enough, with no retry wait and no request outstanding.
    assign cand_diff = now_t - cand_time_s;
    assign req_s     = (cand_s != applied_reg) && (64'(cand_diff) >= 64'(need))
                       && !blocked && !pending_reg;

    // Apply report arithmetic.
    assign flip_inc    = (flip_reg == rmh_pkg::FLIP_COUNT_MAX) ? flip_reg : flip_reg + 8'd1;
    assign hold_end_a  = now_t + TIME_BITS'(cfg.settle_ms);
    assign retry_end_a = now_t + TIME_BITS'(cfg.retry_ms);

    // Next state and result for the request at hand.
    always_comb
    begin
        applied_next      = applied_reg;
        cand_next         = cand_reg;
        cand_time_next    = cand_time_reg;
        window_start_next = window_start_reg;
        flip_next         = flip_reg;
        hold_end_next     = hold_end_reg;
        hold_armed_next   = hold_armed_reg;
        retry_end_next    = retry_end_reg;
        retry_armed_next  = retry_armed_reg;
        unk_start_next    = unk_start_reg;
        unk_seen_next     = unk_seen_reg;
        pending_next      = pending_reg;
        pending_lvl_next  = pending_lvl_reg;
        result            = '0;

        if (item.kind == rmh_pkg::KIND_APPLY_DONE)
        begin
            // A report with nothing outstanding changes nothing.
            if (pending_reg)
            begin
                pending_next = 1'b0;
                if (item.apply_ok)
                begin
                    applied_next = pending_lvl_reg;
                    flip_next    = flip_inc;
                    if (cfg.display_mode)
                    begin
                        hold_end_next   = hold_end_a;
                        hold_armed_next = 1'b1;
                    end
                end
                else
                begin
                    retry_end_next   = retry_end_a;
                    retry_armed_next = 1'b1;
                end
            end
            result.applied_level   = applied_next;
            result.candidate_level = cand_reg;
            result.flap_damped     = (flip_next >= FLIP_TH);
        end
        else
        begin
            unk_seen_next    = unk;
            unk_start_next   = unk_start_s;
            hold_armed_next  = held;
            retry_armed_next = blocked;
            cand_next        = cand_s;
            cand_time_next   = cand_time_s;
            flip_next        = flip_s;
            if (win_roll)
            begin
                window_start_next = now_t;
            end
            if (req_s)
            begin
                pending_next     = 1'b1;
                pending_lvl_next = cand_s;
            end
            result.request_apply   = req_s;
            result.request_high    = req_s && cand_s;
            result.applied_level   = applied_reg;
            result.candidate_level = cand_s;
            result.flap_damped     = flap_s;
        end
    end

    // State registers. Both levels start at base refresh.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            applied_reg      <= 1'b0;
            cand_reg         <= 1'b0;
            cand_time_reg    <= '0;
            window_start_reg <= '0;
            flip_reg         <= 8'd0;
            hold_end_reg     <= '0;
            hold_armed_reg   <= 1'b0;
            retry_end_reg    <= '0;
            retry_armed_reg  <= 1'b0;
            unk_start_reg    <= '0;
            unk_seen_reg     <= 1'b0;
            pending_reg      <= 1'b0;
            pending_lvl_reg  <= 1'b0;
        end
        else if (fire)
        begin
            applied_reg      <= applied_next;
            cand_reg         <= cand_next;
            cand_time_reg    <= cand_time_next;
            window_start_reg <= window_start_next;
            flip_reg         <= flip_next;
            hold_end_reg     <= hold_end_next;
            hold_armed_reg   <= hold_armed_next;
            retry_end_reg    <= retry_end_next;
            retry_armed_reg  <= retry_armed_next;
            unk_start_reg    <= unk_start_next;
            unk_seen_reg     <= unk_seen_next;
            pending_reg      <= pending_next;
            pending_lvl_reg  <= pending_lvl_next;
        end
    end

endmodule

/* rtl/refresh_mode_hysteresis.sv */
`timescale 1ns / 1ps
// ============================================================================
// refresh_mode_hysteresis
// Top level of the refresh mode hysteresis controller: input register,
// decision core, result register and configuration registers.
// ============================================================================

// The block takes one request per clock cycle and returns exactly one result
// for each: the request is captured in an input register, evaluated against
// the controller state in one pass of shallow compare and add logic, and the
// result is held in an output register while the state updates in the same
// edge. The sustained rate is one request per cycle as long as results are
// taken; a stalled result holds the pipeline and stall propagates back to the
// request side. Configuration writes are always ready and should be issued
// only while the block is idle. Both levels start at base refresh after reset.

module refresh_mode_hysteresis #(
    parameter int FLIP_THRESHOLD = 3,
    parameter int FLIP_WINDOW_MS = 30000,
    parameter int TIME_BITS      = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  rmh_pkg::rmh_sample_t sample,
    output logic                 result_valid,
    input  logic                 result_stall,
    output rmh_pkg::rmh_result_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    rmh_pkg::rmh_cfg_t    cfg;
    rmh_pkg::rmh_sample_t item_reg;
    logic                 item_valid_reg, item_valid_next;
    rmh_pkg::rmh_result_t result_reg;
    rmh_pkg::rmh_result_t core_result;
    logic                 result_valid_reg, result_valid_next;
    logic                 advance;
    logic                 fire;
    logic                 accept;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    rmh_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Pipeline flow: the result register frees up when empty or taken.
    assign advance         = !result_valid_reg || !result_stall;
    assign fire            = item_valid_reg && advance;
    assign sample_stall    = item_valid_reg && !advance;
    assign accept          = sample_valid && !sample_stall;
    assign item_valid_next = accept || (item_valid_reg && !advance);
    assign result_valid_next = advance ? fire : result_valid_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= sample;
        end
    end

    // Decision core.
    rmh_core #(
        .FLIP_THRESHOLD (FLIP_THRESHOLD),
        .FLIP_WINDOW_MS (FLIP_WINDOW_MS),
        .TIME_BITS      (TIME_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* tb/refresh_mode_hysteresis_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// refresh_mode_hysteresis_tb
// Self-checking testbench for the refresh mode hysteresis controller. A
// scoreboard class mirrors the candidate/applied level logic and predicts one
// result per accepted request. Plain tasks drive a directed sequence and then
// random timestamp streams under several register settings and idle patterns.
// ============================================================================

module refresh_mode_hysteresis_tb;

    localparam int          ITEMS_PER_PHASE = 175;
    localparam int          PHASES          = 6;
    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          LONG_HOLD       = 300;
    localparam logic [31:0] WINDOW_MS       = 32'd30000;
    localparam logic [7:0]  DAMP_COUNT      = 8'd3;

    // Level predictor and store of expected results.
    class level_scoreboard;
        logic [15:0] promotion_delay;
        logic [15:0] demote_wait;
        logic [15:0] flap_extra;
        logic [15:0] unknown_grace;
        logic [15:0] settle;
        logic [15:0] retry_wait;
        logic        display_mode;

        logic        applied_lvl;
        logic        candidate_lvl;
        logic [31:0] candidate_time;
        logic [31:0] window_start;
        logic [7:0]  flip_count;
        logic [31:0] hold_end;
        bit          hold_armed;
        logic [31:0] retry_end;
        bit          retry_armed;
        logic [31:0] unknown_start;
        bit          unknown_seen;
        bit          apply_pending;
        logic        pending_level;

        rmh_pkg::rmh_result_t expected_levels[$];
        int                   errors;

        function new();
            promotion_delay = rmh_pkg::PROMOTION_DELAY_RST;
            demote_wait     = rmh_pkg::DEMOTION_DELAY_RST;
            flap_extra      = rmh_pkg::FLAP_EXTRA_RST;
            unknown_grace   = rmh_pkg::UNKNOWN_GRACE_RST;
            settle          = rmh_pkg::SETTLE_RST;
            retry_wait      = rmh_pkg::RETRY_RST;
            display_mode    = rmh_pkg::DISPLAY_MODE_RST;
            // The initial level is taken only at reset, which happens once.
            applied_lvl     = 1'b0;
            candidate_lvl   = 1'b0;
            candidate_time  = '0;
            window_start    = '0;
            flip_count      = '0;
            hold_end        = '0;
            hold_armed      = 1'b0;
            retry_end       = '0;
            retry_armed     = 1'b0;
            unknown_start   = '0;
            unknown_seen    = 1'b0;
            apply_pending   = 1'b0;
            pending_level   = 1'b0;
            errors          = 0;
        endfunction

        function void write_reg(rmh_pkg::rmh_reg_idx_t idx, logic [15:0] data);
            unique case (idx)
                rmh_pkg::REG_PROMOTION_DELAY: promotion_delay = data;
                rmh_pkg::REG_DEMOTION_DELAY:  demote_wait     = data;
                rmh_pkg::REG_FLAP_EXTRA:      flap_extra      = data;
                rmh_pkg::REG_UNKNOWN_GRACE:   unknown_grace   = data;
                rmh_pkg::REG_SETTLE:          settle          = data;
                rmh_pkg::REG_RETRY:           retry_wait      = data;
                // The initial level only matters at reset, so a write has
                // no visible effect afterwards.
                rmh_pkg::REG_INITIAL_HIGH:    ;
                rmh_pkg::REG_DISPLAY_MODE:    display_mode    = data[0];
                default: ;
            endcase
        endfunction

        // A deadline is still ahead while now minus the deadline is negative.
        // Once it has passed, the armed bit drops.
        function bit deadline_ahead(inout bit armed, input logic [31:0] deadline,
                                    input logic [31:0] now);
            logic [31:0] diff;
            diff = now - deadline;
            if (!armed)
                return 1'b0;
            if (diff[31])
                return 1'b1;
            armed = 1'b0;
            return 1'b0;
        endfunction

        function rmh_pkg::rmh_result_t decide_levels(rmh_pkg::rmh_sample_t s);
            rmh_pkg::rmh_result_t r;
            logic [31:0] now;
            logic [31:0] base;
            logic [31:0] need;
            bit          held;
            bit          blocked;
            r   = '0;
            now = s.now_ms;
            if (s.kind == rmh_pkg::KIND_APPLY_DONE)
            begin
                // A report with nothing pending is ignored.
                if (apply_pending)
                begin
                    apply_pending = 1'b0;
                    if (s.apply_ok)
                    begin
                        applied_lvl = pending_level;
                        if (flip_count != rmh_pkg::FLIP_COUNT_MAX)
                            flip_count = flip_count + 8'd1;
                        if (display_mode)
                        begin
                            hold_end   = now + {16'd0, settle};
                            hold_armed = 1'b1;
                        end
                    end
                    else
                    begin
                        retry_end   = now + {16'd0, retry_wait};
                        retry_armed = 1'b1;
                    end
                end
            end
            else
            begin
                // Track the start of a run of unknown verdicts.
                if (s.verdict == rmh_pkg::VERDICT_UNKNOWN)
                begin
                    if (!unknown_seen)
                    begin
                        unknown_seen  = 1'b1;
                        unknown_start = now;
                    end
                end
                else
                begin
                    unknown_seen  = 1'b0;
                    unknown_start = '0;
                end

                // Candidate update: hold after own change, unknown bridge, follow.
                held = deadline_ahead(hold_armed, hold_end, now);
                if (held)
                begin
                    candidate_lvl  = applied_lvl;
                    candidate_time = now;
                end
                else if (s.verdict == rmh_pkg::VERDICT_UNKNOWN &&
                         (now - unknown_start) < {16'd0, unknown_grace})
                begin
                end
                else if (s.signal_active != candidate_lvl)
                begin
                    candidate_lvl  = s.signal_active;
                    candidate_time = now;
                end

                if ((now - window_start) > WINDOW_MS)
                begin
                    window_start = now;
                    flip_count   = '0;
                end

                // Required qualification time for the current candidate.
                if (candidate_lvl && s.signal_strong)
                    base = '0;
                else if (candidate_lvl)
                    base = {16'd0, promotion_delay};
                else
                    base = {16'd0, demote_wait};
                need = (flip_count >= DAMP_COUNT) ? base + {16'd0, flap_extra} : base;

                blocked = deadline_ahead(retry_armed, retry_end, now);
                if (candidate_lvl != applied_lvl && (now - candidate_time) >= need &&
                    !blocked && !apply_pending)
                begin
                    r.request_apply = 1'b1;
                    r.request_high  = candidate_lvl;
                    apply_pending   = 1'b1;
                    pending_level   = candidate_lvl;
                end
            end
            r.applied_level   = applied_lvl;
            r.candidate_level = candidate_lvl;
            r.flap_damped     = (flip_count >= DAMP_COUNT);
            return r;
        endfunction

        function void note_request(rmh_pkg::rmh_sample_t s);
            expected_levels = {expected_levels, decide_levels(s)};
        endfunction

        function void check_result(rmh_pkg::rmh_result_t got);
            rmh_pkg::rmh_result_t exp;
            if (expected_levels.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result with no request outstanding: %b", got);
                return;
            end
            exp = expected_levels.pop_front();
            if (got.request_apply !== exp.request_apply ||
                got.request_high !== exp.request_high ||
                got.applied_level !== exp.applied_level ||
                got.candidate_level !== exp.candidate_level ||
                got.flap_damped !== exp.flap_damped)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected req/high/applied/cand/damp %b, got %b",
                             exp, got);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    rmh_pkg::rmh_sample_t sample       = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    rmh_pkg::rmh_result_t result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [2:0]           cfg_index    = rmh_pkg::REG_PROMOTION_DELAY;
    logic [15:0]          cfg_data     = '0;

    level_scoreboard sb;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_req;
    int          hold_left;
    int          cycles;
    logic [31:0] cur_time;
    logic        act_level;
    int          unknown_left;
    logic [15:0] cfg_plan [8];

    refresh_mode_hysteresis uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("refresh_mode_hysteresis_tb: errors");
                $finish;
            end
        end
    end

    // Result side: random stall, or a long hold-off when one is asked for.
    initial
    begin
        hold_req  = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
                result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Every accepted result is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    function automatic rmh_pkg::rmh_sample_t make_request(logic kind, logic [31:0] now,
                                                          logic [1:0] verdict,
                                                          logic active,
                                                          logic strong_src, logic ok);
        rmh_pkg::rmh_sample_t s;
        s.kind          = kind;
        s.now_ms        = now;
        s.verdict       = verdict;
        s.signal_active = active;
        s.signal_strong = strong_src;
        s.apply_ok      = ok;
        return s;
    endfunction

    // Offer one request after a random idle gap and wait for its acceptance.
    task automatic send_request(input rmh_pkg::rmh_sample_t s);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        sb.note_request(s);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_results();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (sb.expected_levels.size() != 0)
            @(posedge clk);
    endtask

    // Write all registers from cfg_plan while the block is idle.
    task automatic write_config();
        repeat (4) @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= rmh_pkg::rmh_reg_idx_t'(i);
            cfg_data  <= cfg_plan[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.write_reg(rmh_pkg::rmh_reg_idx_t'(i), cfg_plan[i]);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Directed walk through promotion, failure, retry, hold, bridge and damping.
    task automatic run_directed();
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd0,
                                  rmh_pkg::VERDICT_DESKTOP, 1'b0, 1'b0, 1'b0));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd100,
                                  rmh_pkg::VERDICT_FULLSCREEN, 1'b1, 1'b1, 1'b0));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd150,
                                  rmh_pkg::VERDICT_FULLSCREEN, 1'b1, 1'b1, 1'b0));
        send_request(make_request(rmh_pkg::KIND_APPLY_DONE, 32'd200,
                                  rmh_pkg::VERDICT_DESKTOP, 1'b0, 1'b0, 1'b1));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd300,
                                  rmh_pkg::VERDICT_DESKTOP, 1'b0, 1'b0, 1'b0));
        send_request(make_request(rmh_pkg::KIND_APPLY_DONE, 32'd350,
                                  rmh_pkg::VERDICT_OTHER, 1'b1, 1'b1, 1'b0));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd1300,
                                  rmh_pkg::VERDICT_OTHER, 1'b0, 1'b0, 1'b0));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd2900,
                                  rmh_pkg::VERDICT_OTHER, 1'b0, 1'b0, 1'b0));
        send_request(make_request(rmh_pkg::KIND_APPLY_DONE, 32'd3000,
                                  rmh_pkg::VERDICT_DESKTOP, 1'b0, 1'b0, 1'b0));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd3100,
                                  rmh_pkg::VERDICT_DESKTOP, 1'b0, 1'b0, 1'b0));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd5100,
                                  rmh_pkg::VERDICT_DESKTOP, 1'b0, 1'b0, 1'b0));
        send_request(make_request(rmh_pkg::KIND_APPLY_DONE, 32'd5200,
                                  rmh_pkg::VERDICT_DESKTOP, 1'b0, 1'b0, 1'b1));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd6300,
                                  rmh_pkg::VERDICT_UNKNOWN, 1'b1, 1'b0, 1'b0));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd9000,
                                  rmh_pkg::VERDICT_UNKNOWN, 1'b1, 1'b0, 1'b0));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd11400,
                                  rmh_pkg::VERDICT_UNKNOWN, 1'b1, 1'b0, 1'b0));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd11800,
                                  rmh_pkg::VERDICT_FULLSCREEN, 1'b1, 1'b0, 1'b0));
        send_request(make_request(rmh_pkg::KIND_APPLY_DONE, 32'd11900,
                                  rmh_pkg::VERDICT_FULLSCREEN, 1'b1, 1'b0, 1'b1));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd13000,
                                  rmh_pkg::VERDICT_DESKTOP, 1'b0, 1'b0, 1'b0));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd20000,
                                  rmh_pkg::VERDICT_DESKTOP, 1'b0, 1'b0, 1'b0));
        send_request(make_request(rmh_pkg::KIND_APPLY_DONE, 32'd20100,
                                  rmh_pkg::VERDICT_DESKTOP, 1'b0, 1'b0, 1'b1));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd60000,
                                  rmh_pkg::VERDICT_DESKTOP, 1'b1, 1'b1, 1'b0));
        // All-ones fields, then a wrap of the timestamp back to zero.
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'hFFFF_FFFF,
                                  rmh_pkg::VERDICT_OTHER, 1'b1, 1'b1, 1'b1));
        send_request(make_request(rmh_pkg::KIND_APPLY_DONE, 32'hFFFF_FFFF,
                                  rmh_pkg::VERDICT_OTHER, 1'b1, 1'b1, 1'b1));
        send_request(make_request(rmh_pkg::KIND_SAMPLE, 32'd0,
                                  rmh_pkg::VERDICT_FULLSCREEN, 1'b0, 1'b0, 1'b0));
        cur_time = 32'd100;
    endtask

    // Random timestamp stream: mostly small steps with an activity level that
    // changes now and then, runs of unknown verdicts and apply reports that
    // answer outstanding requests; some jumps and stray reports as noise.
    task automatic run_random(input int count, input bit pressure);
        logic        kind;
        logic [1:0]  verdict;
        logic        ok;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            if (pressure && n == 40)
                hold_req = LONG_HOLD;
            if (pressure && n == 100)
                drain_results();

            pick = $urandom_range(0, 99);
            if (pick < 2)
                cur_time = $urandom;
            else if (pick < 8)
                cur_time = cur_time + $urandom_range(1000, 70000);
            else
                cur_time = cur_time + $urandom_range(0, 400);

            if (sb.apply_pending && $urandom_range(0, 2) == 0)
            begin
                kind = rmh_pkg::KIND_APPLY_DONE;
                ok   = ($urandom_range(0, 3) != 0);
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                kind = rmh_pkg::KIND_APPLY_DONE;
                ok   = 1'($urandom_range(0, 1));
            end
            else
            begin
                kind = rmh_pkg::KIND_SAMPLE;
                ok   = 1'($urandom_range(0, 1));
            end

            if (unknown_left > 0)
            begin
                verdict = rmh_pkg::VERDICT_UNKNOWN;
                unknown_left--;
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                verdict      = rmh_pkg::VERDICT_UNKNOWN;
                unknown_left = $urandom_range(1, 20);
            end
            else
            begin
                verdict = 2'($urandom_range(0, 3));
                if (verdict == rmh_pkg::VERDICT_UNKNOWN)
                    verdict = rmh_pkg::VERDICT_DESKTOP;
            end

            if ($urandom_range(0, 9) == 0)
                act_level = ~act_level;

            send_request(make_request(kind, cur_time, verdict, act_level,
                                      ($urandom_range(0, 2) == 0), ok));
        end
    endtask

    // Register values for each phase after the first.
    task automatic plan_config(input int phase);
        unique case (phase)
            1:
            begin
                for (int i = 0; i < 8; i++)
                    cfg_plan[i] = 16'd0;
                cfg_plan[rmh_pkg::REG_INITIAL_HIGH] = 16'd1;
                cfg_plan[rmh_pkg::REG_DISPLAY_MODE] = 16'd0;
            end
            2:
            begin
                for (int i = 0; i < 8; i++)
                    cfg_plan[i] = 16'hFFFF;
                cfg_plan[rmh_pkg::REG_INITIAL_HIGH] = 16'd0;
                cfg_plan[rmh_pkg::REG_DISPLAY_MODE] = 16'd1;
            end
            3:
            begin
                for (int i = 0; i < 8; i++)
                    cfg_plan[i] = 16'($urandom_range(0, 3000));
                cfg_plan[rmh_pkg::REG_INITIAL_HIGH] = 16'($urandom_range(0, 1));
                cfg_plan[rmh_pkg::REG_DISPLAY_MODE] = 16'($urandom_range(0, 1));
            end
            4:
            begin
                cfg_plan[rmh_pkg::REG_PROMOTION_DELAY] = rmh_pkg::PROMOTION_DELAY_RST;
                cfg_plan[rmh_pkg::REG_DEMOTION_DELAY]  = rmh_pkg::DEMOTION_DELAY_RST;
                cfg_plan[rmh_pkg::REG_FLAP_EXTRA]      = rmh_pkg::FLAP_EXTRA_RST;
                cfg_plan[rmh_pkg::REG_UNKNOWN_GRACE]   = rmh_pkg::UNKNOWN_GRACE_RST;
                cfg_plan[rmh_pkg::REG_SETTLE]          = rmh_pkg::SETTLE_RST;
                cfg_plan[rmh_pkg::REG_RETRY]           = rmh_pkg::RETRY_RST;
                cfg_plan[rmh_pkg::REG_INITIAL_HIGH]    = 16'd1;
                cfg_plan[rmh_pkg::REG_DISPLAY_MODE]    = {15'd0, rmh_pkg::DISPLAY_MODE_RST};
            end
            default:
            begin
                // Upper bits of the data word are written too; only bit 0 counts for the
                // display mode register, and the initial level register ignores the word.
                for (int i = 0; i < 8; i++)
                    cfg_plan[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                              : 16'($urandom_range(0, 2500));
            end
        endcase
    endtask

    // Main sequence.
    initial
    begin
        sb            = new();
        send_idle_pct = 25;
        recv_idle_pct = 85;
        act_level     = 1'b0;
        unknown_left  = 0;
        cur_time      = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain_results();
                plan_config(phase);
                write_config();
            end
            if (phase < 2)
            begin
                send_idle_pct = 25;
                recv_idle_pct = 85;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random(ITEMS_PER_PHASE, phase == 4);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.expected_levels.size() == 0)
            $display("refresh_mode_hysteresis_tb: clean");
        else
            $display("refresh_mode_hysteresis_tb: errors");
        $finish;
    end

endmodule
